>>> hdl/fcpwm_pkg.sv
// ----------------------------------------------------------------------------
// fcpwm_pkg: shared types and constants of the four-channel PWM timer.
// Holds the beat structs, command codes, register indexes and widths.
// ----------------------------------------------------------------------------
package fcpwm_pkg;

  localparam int CHANNELS_DEF     = 4;
  localparam int COUNTER_BITS_DEF = 16;
  localparam int CMP_W            = 17;
  localparam int DUTY_FULL        = 100;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_SET_DUTY   = 3'd1,
    CMD_SET_PULSE  = 3'd2,
    CMD_READ_DUTY  = 3'd3,
    CMD_READ_PULSE = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    REG_PRESCALE = 2'd0,
    REG_PERIOD   = 2'd1,
    REG_ENABLE   = 2'd2
  } reg_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  channel;
    logic [15:0] value;
    logic [4:0]  resolution;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [16:0] read_value;
    logic [3:0]  pwm_out;
  } out_item_t;

  // Classified operation handed from the front end to the execution unit.
  typedef enum logic [2:0] {
    OP_TICK,
    OP_FAIL,
    OP_SET,
    OP_READ_DUTY,
    OP_READ_PULSE
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [2:0]  channel;
    logic [47:0] dividend;
    logic [16:0] divisor;
  } job_t;

endpackage

>>> hdl/fcpwm_front.sv
// ----------------------------------------------------------------------------
// fcpwm_front: accepts input beats, validates channel and command, and
// prepares each conversion's divisor, and a write's dividend, as a queued job.
// ----------------------------------------------------------------------------
module fcpwm_front #(
  parameter int CHANNELS = fcpwm_pkg::CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fcpwm_pkg::in_item_t   in_data,
  input  logic [15:0]           period_minus_one,
  input  logic [CHANNELS-1:0]   channel_enable,
  output logic                  job_valid,
  input  logic                  job_ready,
  output fcpwm_pkg::job_t       job
);

  logic            busy;
  fcpwm_pkg::job_t job_next;
  logic            valid_ch;
  logic [16:0]     span;
  logic [6:0]      duty;
  logic [4:0]      res;
  logic [16:0]     mval;
  logic [15:0]     pclamp;

  assign in_ready    = !busy || job_ready;
  assign job_valid   = busy;
  assign span        = {1'b0, period_minus_one} + 17'd1;

  always_comb begin
    valid_ch = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (in_data.channel == 3'(i) && channel_enable[i]) valid_ch = 1'b1;
    end
  end

  // Conversion operands; the product is formed before the divider.
  // The duty read takes its compare value in the execution unit, so that a
  // write still in progress there is seen.
  always_comb begin
    duty   = (in_data.value > 16'(fcpwm_pkg::DUTY_FULL)) ? 7'(fcpwm_pkg::DUTY_FULL)
                                                         : in_data.value[6:0];
    res    = (in_data.resolution < 5'd1) ? 5'd1 :
             ((in_data.resolution > 5'd16) ? 5'd16 : in_data.resolution);
    mval   = (17'd1 << res) - 17'd1;
    pclamp = ({1'b0, in_data.value} > mval) ? mval[15:0] : in_data.value;
    job_next.channel  = in_data.channel;
    job_next.dividend = '0;
    job_next.divisor  = 17'd1;
    if (in_data.cmd == fcpwm_pkg::CMD_TICK) begin
      job_next.op = fcpwm_pkg::OP_TICK;
    end else if (in_data.cmd > fcpwm_pkg::CMD_READ_PULSE || !valid_ch) begin
      job_next.op = fcpwm_pkg::OP_FAIL;
    end else begin
      unique case (in_data.cmd)
        fcpwm_pkg::CMD_SET_DUTY: begin
          job_next.op       = fcpwm_pkg::OP_SET;
          job_next.dividend = 48'({7'd0, span} * {17'd0, duty});
          job_next.divisor  = 17'(fcpwm_pkg::DUTY_FULL);
        end
        fcpwm_pkg::CMD_SET_PULSE: begin
          job_next.op       = fcpwm_pkg::OP_SET;
          job_next.dividend = 48'({16'd0, span} * {17'd0, pclamp});
          job_next.divisor  = mval;
        end
        fcpwm_pkg::CMD_READ_DUTY: begin
          job_next.op       = fcpwm_pkg::OP_READ_DUTY;
          job_next.divisor  = (period_minus_one == 16'd0) ? 17'd1
                                                          : {1'b0, period_minus_one};
        end
        default: begin
          job_next.op = fcpwm_pkg::OP_READ_PULSE;
        end
      endcase
    end
  end

  // One-entry queue toward the execution unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
    end else if (job_ready) begin
      busy <= 1'b0;
    end
    if (in_valid && in_ready) job <= job_next;
  end

endmodule

>>> hdl/fcpwm_back.sv
// ----------------------------------------------------------------------------
// fcpwm_back: executes jobs with a bit-serial divider, owns the counters and
// compare registers, and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module fcpwm_back #(
  parameter int CHANNELS     = fcpwm_pkg::CHANNELS_DEF,
  parameter int COUNTER_BITS = fcpwm_pkg::COUNTER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  fcpwm_pkg::job_t       job,
  input  logic [15:0]           prescale_minus_one,
  input  logic [15:0]           period_minus_one,
  input  logic [CHANNELS-1:0]   channel_enable,
  input  logic [CHANNELS-1:0]   clear_pending,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fcpwm_pkg::out_item_t  out_data
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_t;

  localparam int STEPS = 48;

  state_t                state;
  logic [5:0]            step;
  logic [47:0]           quo;
  logic [16:0]           rem;
  logic [17:0]           trial;
  fcpwm_pkg::job_t       cur;
  logic [COUNTER_BITS-1:0] prescale_count;
  logic [COUNTER_BITS-1:0] period_count;
  logic [16:0]           pending [CHANNELS];
  logic [16:0]           active  [CHANNELS];
  logic [CHANNELS-1:0]   levels;
  logic                  out_free;
  logic                  done_now;
  logic                  pre_wrap;
  logic                  per_wrap;
  logic [16:0]           pend_job;
  logic [16:0]           pend_cur;
  logic [16:0]           rv_next;
  logic [CHANNELS-1:0]   pwm_next;

  assign out_free  = !out_valid || out_ready;
  assign job_ready = (state == S_IDLE) && out_free;
  assign done_now  = (state == S_DONE) && out_free;
  assign trial     = {rem, quo[47]} - {1'b0, cur.divisor};
  assign pre_wrap  = prescale_count >= COUNTER_BITS'(prescale_minus_one);
  assign per_wrap  = period_count >= COUNTER_BITS'(period_minus_one);

  // Compare values of the incoming job's channel and of the current job's.
  always_comb begin
    pend_job = '0;
    pend_cur = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (job.channel == 3'(i)) pend_job = pending[i];
      if (cur.channel == 3'(i)) pend_cur = pending[i];
    end
  end

  // Output levels for a given period count.
  function automatic logic [CHANNELS-1:0] lv(input logic [COUNTER_BITS-1:0] pc);
    logic [CHANNELS-1:0] r;
    for (int i = 0; i < CHANNELS; i++) begin
      r[i] = channel_enable[i] && (COUNTER_BITS'(pc) < active[i]);
    end
    return r;
  endfunction

  always_comb levels = lv(period_count);

  // Result fields of the current job, with the channel levels after the job.
  always_comb begin
    rv_next  = '0;
    pwm_next = levels;
    unique case (cur.op)
      fcpwm_pkg::OP_TICK: begin
        if (pre_wrap) begin
          if (per_wrap) begin
            for (int i = 0; i < CHANNELS; i++) begin
              pwm_next[i] = channel_enable[i] && (pending[i] != 17'd0);
            end
          end else begin
            pwm_next = lv(period_count + 1'b1);
          end
        end
      end
      fcpwm_pkg::OP_READ_DUTY:  rv_next = {9'd0, quo[7:0]};
      fcpwm_pkg::OP_READ_PULSE: rv_next = pend_cur;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      prescale_count <= '0;
      period_count   <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pending[i] <= '0;
        active[i]  <= '0;
      end
    end else begin
      if (done_now) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // Channel start clears the compare; a finished write loads it.
      for (int i = 0; i < CHANNELS; i++) begin
        if (clear_pending[i]) begin
          pending[i] <= '0;
        end else if (done_now && cur.op == fcpwm_pkg::OP_SET && cur.channel == 3'(i)) begin
          pending[i] <= quo[16:0];
        end
      end
      // Prescaler and period counter advance on a finished tick.
      if (done_now && cur.op == fcpwm_pkg::OP_TICK) begin
        if (pre_wrap) begin
          prescale_count <= '0;
          if (per_wrap) begin
            period_count <= '0;
            for (int i = 0; i < CHANNELS; i++) active[i] <= pending[i];
          end else begin
            period_count <= period_count + 1'b1;
          end
        end else begin
          prescale_count <= prescale_count + 1'b1;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            cur   <= job;
            quo   <= (job.op == fcpwm_pkg::OP_READ_DUTY)
                     ? 48'({7'd0, pend_job} * 24'(fcpwm_pkg::DUTY_FULL))
                     : job.dividend;
            rem   <= '0;
            step  <= '0;
            state <= (job.op == fcpwm_pkg::OP_SET ||
                      job.op == fcpwm_pkg::OP_READ_DUTY) ? S_DIV : S_DONE;
          end
        end
        // Restoring division, one quotient bit per cycle.
        S_DIV: begin
          if (!trial[17]) begin
            rem <= trial[16:0];
            quo <= {quo[46:0], 1'b1};
          end else begin
            rem <= {rem[15:0], quo[47]};
            quo <= {quo[46:0], 1'b0};
          end
          if (step == 6'(STEPS - 1)) state <= S_DONE;
          step <= step + 6'd1;
        end
        S_DONE: begin
          if (out_free) begin
            state               <= S_IDLE;
            out_data.ok         <= (cur.op != fcpwm_pkg::OP_FAIL);
            out_data.read_value <= rv_next;
            out_data.pwm_out    <= 4'(pwm_next);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/four_channel_pwm_timer.sv
// ----------------------------------------------------------------------------
// four_channel_pwm_timer: four-channel edge-aligned PWM timer.
// Top level with configuration registers, front end and execution unit.
// ----------------------------------------------------------------------------
// Usage: input beats (in_valid/in_ready) carry a tick, a duty or pulse write,
// or a duty or pulse read. Each gives exactly one result beat on
// out_valid/out_ready with ok, read_value and the channel levels after the
// item. Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set
// the prescaler, period and channel enables, and must be issued only while
// no item is in flight.
// Ticks, failures and pulse reads pass from the front-end job register through
// the execution unit to the result register; duty and pulse writes and duty
// reads also pass through the shared restoring divider, which produces one
// quotient bit per cycle over a 48-bit dividend. One item is executed at a
// time; the front end holds one more.
// Reset (rst, synchronous) clears counters, compares and enables, and sets
// the period to its maximum. A stalled receiver holds the result register,
// and the execution unit then stops before finishing the next item.
// ----------------------------------------------------------------------------
module four_channel_pwm_timer #(
  parameter int CHANNELS     = fcpwm_pkg::CHANNELS_DEF,
  parameter int COUNTER_BITS = fcpwm_pkg::COUNTER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fcpwm_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fcpwm_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [15:0]          prescale_minus_one;
  logic [15:0]          period_minus_one;
  logic [CHANNELS-1:0]  channel_enable;
  logic [CHANNELS-1:0]  clear_pending;
  logic [CHANNELS-1:0]  enable_new;
  logic                 job_valid;
  logic                 job_ready;
  fcpwm_pkg::job_t      job;

  assign cfg_ready  = 1'b1;
  assign enable_new = CHANNELS'(cfg_data[3:0]);
  assign clear_pending = (cfg_valid && cfg_index == fcpwm_pkg::REG_ENABLE)
                         ? (enable_new & ~channel_enable) : '0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_minus_one <= '0;
      period_minus_one   <= 16'hFFFF;
      channel_enable     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fcpwm_pkg::REG_PRESCALE: prescale_minus_one <= cfg_data;
        fcpwm_pkg::REG_PERIOD:   period_minus_one   <= cfg_data;
        fcpwm_pkg::REG_ENABLE:   channel_enable     <= enable_new;
        default: ;
      endcase
    end
  end

  fcpwm_front #(.CHANNELS(CHANNELS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .period_minus_one, .channel_enable,
    .job_valid, .job_ready, .job
  );

  fcpwm_back #(.CHANNELS(CHANNELS), .COUNTER_BITS(COUNTER_BITS)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .prescale_minus_one, .period_minus_one, .channel_enable, .clear_pending,
    .out_valid, .out_ready, .out_data
  );

  // A held result must not change while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A failed command never reports a value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ok |-> out_data.read_value == 17'd0)
    else $error("failed command returned a value");

  // The job queue keeps its beat until the execution unit takes it.
  a_job_hold: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid && $stable(job))
    else $error("queued job lost");

endmodule

>>> test/tb_four_channel_pwm_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_channel_pwm_timer: self-checking bench for the four-channel PWM timer.
// Random and directed command beats are driven from a queue. An internal timer
// model predicts each result beat, and a monitor compares it field by field.
// ----------------------------------------------------------------------------
module tb_four_channel_pwm_timer;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  fcpwm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fcpwm_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  four_channel_pwm_timer u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Timer model state.
  logic [15:0] m_prescale, m_period, m_pre_cnt, m_per_cnt;
  logic [3:0]  m_enable;
  logic [16:0] m_pending [4];
  logic [16:0] m_active [4];

  fcpwm_pkg::in_item_t  cmd_queue [$];
  fcpwm_pkg::out_item_t result_queue [$];
  int errors = 0;
  int sent = 0;
  int got = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %0h expected %0h (result %0d)", what, seen, want, got);
    errors++;
  endtask

  function automatic void timer_reset();
    m_prescale = '0; m_period = 16'hFFFF; m_enable = '0;
    m_pre_cnt = '0; m_per_cnt = '0;
    for (int i = 0; i < 4; i++) begin
      m_pending[i] = '0; m_active[i] = '0;
    end
  endfunction

  function automatic void timer_write_reg(input fcpwm_pkg::reg_e idx, input logic [15:0] d);
    logic [3:0] rising;
    case (idx)
      fcpwm_pkg::REG_PRESCALE: m_prescale = d;
      fcpwm_pkg::REG_PERIOD: m_period = d;
      fcpwm_pkg::REG_ENABLE: begin
        rising = d[3:0] & ~m_enable;
        for (int i = 0; i < 4; i++) if (rising[i]) m_pending[i] = '0;
        m_enable = d[3:0];
      end
      default: ;
    endcase
  endfunction

  // Computes the result of one command beat and advances the model.
  function automatic fcpwm_pkg::out_item_t timer_execute(input fcpwm_pkg::in_item_t it);
    fcpwm_pkg::out_item_t r;
    logic [63:0] span, q;
    logic [4:0] res;
    logic [16:0] m, p, dv;
    logic [15:0] d;
    bit valid_ch;
    r = '0;
    valid_ch = it.channel < 4 && m_enable[it.channel[1:0]];
    span = 64'(m_period) + 64'd1;
    if (it.cmd == fcpwm_pkg::CMD_TICK) begin
      r.ok = 1'b1;
      if (m_pre_cnt >= m_prescale) begin
        m_pre_cnt = '0;
        if (m_per_cnt >= m_period) begin
          m_per_cnt = '0;
          for (int i = 0; i < 4; i++) m_active[i] = m_pending[i];
        end else begin
          m_per_cnt = m_per_cnt + 16'd1;
        end
      end else begin
        m_pre_cnt = m_pre_cnt + 16'd1;
      end
    end else if (it.cmd <= fcpwm_pkg::CMD_READ_PULSE && valid_ch) begin
      r.ok = 1'b1;
      case (it.cmd)
        fcpwm_pkg::CMD_SET_DUTY: begin
          d = it.value > fcpwm_pkg::DUTY_FULL ? 16'(fcpwm_pkg::DUTY_FULL) : it.value;
          q = (span * d) / 64'(fcpwm_pkg::DUTY_FULL);
          m_pending[it.channel[1:0]] = q[16:0];
        end
        fcpwm_pkg::CMD_SET_PULSE: begin
          res = it.resolution < 1 ? 5'd1 : (it.resolution > 16 ? 5'd16 : it.resolution);
          m = (17'd1 << res) - 17'd1;
          p = it.value > m ? m : 17'(it.value);
          q = (64'(p) * span) / 64'(m);
          m_pending[it.channel[1:0]] = q[16:0];
        end
        fcpwm_pkg::CMD_READ_DUTY: begin
          dv = m_period == 0 ? 17'd1 : 17'(m_period);
          q = (64'(m_pending[it.channel[1:0]]) * 64'(fcpwm_pkg::DUTY_FULL)) / 64'(dv);
          r.read_value = 17'(q[7:0]);
        end
        default: r.read_value = m_pending[it.channel[1:0]];
      endcase
    end
    for (int i = 0; i < 4; i++)
      r.pwm_out[i] = m_enable[i] && (17'(m_per_cnt) < m_active[i]);
    return r;
  endfunction

  // Driver: offers queued command beats, idling at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        result_queue.push_back(timer_execute(in_data));
        sent++;
      end
      if (!in_valid || in_ready) begin
        if (cmd_queue.size() > 0 && (quiet || $urandom_range(99) >= 37)) begin
          in_data <= cmd_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    fcpwm_pkg::out_item_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got++;
        if (result_queue.size() == 0) begin
          report_mismatch("unexpected beat", 32'(out_data), 32'd0);
        end else begin
          e = result_queue.pop_front();
          if (out_data.ok !== e.ok) report_mismatch("ok", 32'(out_data.ok), 32'(e.ok));
          if (out_data.read_value !== e.read_value)
            report_mismatch("read_value", 32'(out_data.read_value), 32'(e.read_value));
          if (out_data.pwm_out !== e.pwm_out)
            report_mismatch("pwm_out", 32'(out_data.pwm_out), 32'(e.pwm_out));
        end
      end
      out_ready <= !hold_off && (quiet || $urandom_range(99) >= 37);
    end
  end

  task automatic write_reg(input fcpwm_pkg::reg_e idx, input logic [15:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    timer_write_reg(idx, d);
  endtask

  task automatic drain();
    while (cmd_queue.size() > 0 || in_valid || result_queue.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic fcpwm_pkg::in_item_t rand_item();
    fcpwm_pkg::in_item_t it;
    it.cmd = $urandom_range(99) < 45 ? fcpwm_pkg::CMD_TICK : 3'($urandom_range(7));
    if ($urandom_range(19) == 0) it.cmd = 3'($urandom_range(7, 5));
    it.channel = $urandom_range(9) == 0 ? 3'($urandom_range(7, 4)) : 3'($urandom_range(3));
    case ($urandom_range(3))
      0: it.value = 16'($urandom_range(120));
      1: it.value = 16'($urandom);
      2: it.value = $urandom_range(1) ? 16'hFFFF : 16'h0;
      default: it.value = 16'($urandom_range(1023));
    endcase
    it.resolution = 5'($urandom);
    return it;
  endfunction

  function automatic fcpwm_pkg::in_item_t mk(input logic [2:0] c, input logic [2:0] ch,
                                             input logic [15:0] v, input logic [4:0] r);
    fcpwm_pkg::in_item_t it;
    it.cmd = c; it.channel = ch; it.value = v; it.resolution = r;
    return it;
  endfunction

  initial begin
    logic [15:0] pre_set [6];
    logic [15:0] per_set [6];
    pre_set = '{16'd0, 16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd2};
    per_set = '{16'd1, 16'd7, 16'hFFFF, 16'd20, 16'd5, 16'd0};
    timer_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extremes, every command, rejected channels and codes.
    write_reg(fcpwm_pkg::REG_PERIOD, 16'd9);
    write_reg(fcpwm_pkg::REG_ENABLE, 16'h000B);
    cmd_queue.push_back(mk(fcpwm_pkg::CMD_SET_DUTY, 3'd0, 16'd50, 5'd0));
    cmd_queue.push_back(mk(fcpwm_pkg::CMD_SET_DUTY, 3'd1, 16'hFFFF, 5'd0));
    cmd_queue.push_back(mk(fcpwm_pkg::CMD_SET_DUTY, 3'd2, 16'd30, 5'd0));
    cmd_queue.push_back(mk(fcpwm_pkg::CMD_SET_DUTY, 3'd5, 16'd30, 5'd0));
    cmd_queue.push_back(mk(fcpwm_pkg::CMD_SET_PULSE, 3'd3, 16'hFFFF, 5'd0));
    cmd_queue.push_back(mk(fcpwm_pkg::CMD_SET_PULSE, 3'd3, 16'd3, 5'd31));
    cmd_queue.push_back(mk(fcpwm_pkg::CMD_SET_PULSE, 3'd0, 16'd100, 5'd16));
    cmd_queue.push_back(mk(fcpwm_pkg::CMD_READ_PULSE, 3'd0, 16'd0, 5'd0));
    cmd_queue.push_back(mk(fcpwm_pkg::CMD_READ_DUTY, 3'd1, 16'd0, 5'd0));
    cmd_queue.push_back(mk(fcpwm_pkg::CMD_READ_PULSE, 3'd7, 16'd0, 5'd0));
    cmd_queue.push_back(mk(3'd7, 3'd0, 16'hFFFF, 5'h1F));
    cmd_queue.push_back(mk(3'd5, 3'd1, 16'd0, 5'd0));
    for (int i = 0; i < 12; i++)
      cmd_queue.push_back(mk(fcpwm_pkg::CMD_TICK, 3'd0, 16'd0, 5'd0));
    drain();

    // Receiver holds off for a long stretch so the block backs up.
    for (int i = 0; i < 40; i++) cmd_queue.push_back(rand_item());
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
    drain();

    // Random phases over several settings, one with no idling at all.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(fcpwm_pkg::REG_PRESCALE, pre_set[ph]);
      write_reg(fcpwm_pkg::REG_PERIOD, per_set[ph]);
      write_reg(fcpwm_pkg::REG_ENABLE, ph == 5 ? 16'h000F : 16'($urandom_range(15)));
      quiet = (ph == 2);
      for (int i = 0; i < 150; i++) cmd_queue.push_back(rand_item());
      drain();
    end
    write_reg(fcpwm_pkg::REG_ENABLE, 16'h0000);
    cmd_queue.push_back(mk(fcpwm_pkg::CMD_READ_PULSE, 3'd0, 16'd0, 5'd0));
    cmd_queue.push_back(mk(fcpwm_pkg::CMD_TICK, 3'd0, 16'd0, 5'd0));
    drain();

    if (errors == 0 && result_queue.size() == 0) begin
      $display("** four_channel_pwm_timer: PASSED **");
    end else begin
      $display("** four_channel_pwm_timer: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4000000;
    $display("** four_channel_pwm_timer: FAILED **");
    $finish;
  end
endmodule
